[rtl/cod_pkg.sv]
// cod_pkg: shared types and constants of the causal order delivery buffer
// depends on nothing; used by the top level and its checker
package cod_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ARRIVE,
		ST_READ,
		ST_EVAL,
		ST_FLUSH
	} state_t;

	localparam logic [1:0] KIND_DELIVER = 2'd0;
	localparam logic [1:0] KIND_STAMP   = 2'd1;
	localparam logic [1:0] KIND_DROP    = 2'd2;

	localparam logic MODE_RECV  = 1'b0;
	localparam logic MODE_BCAST = 1'b1;

	localparam int ID_W      = 3;
	localparam int SENDER_W  = 3;
	localparam int TAG_W     = 16;
	localparam int TS_W      = 16;
	localparam int TS_FIELDS = 5;
	localparam int S_DATA_W  = 104;
	localparam int M_DATA_W  = 96;

endpackage

[rtl/causal_order_delivery_buffer.sv]
// causal_order_delivery_buffer: vector-clock causal delivery with a pending store
// depends on cod_pkg; the pending store is one synchronous memory in this file
//
// usage
//   s_* carries one word per message: tuser is the mode (receive or broadcast),
//   tdata the sender, tag and vector stamp. m_* returns results: tuser is the
//   kind, tdata the tag and stamp, tlast marks the final result of an input word.
//   cfg_* writes own_id; write it only while the block is idle.
// sequencing
//   a broadcast goes from the arrive state to the flush state. a received word is
//   tested in the arrive state, then every pending entry is taken through a read
//   and an evaluate and compact-write step in each rescan pass through the store
//   memory; passes repeat while a pass delivers and entries remain.
//   one word is worked on at a time; s_tready is high only when idle.
// reset
//   clears counters, local clock, store fill count and own_id; no clearing pass.
// stall
//   results are held one deep plus the output register; a stalled receiver
//   holds the rescan at a delivering entry until the output register frees.
module causal_order_delivery_buffer #(
	parameter int PROCS         = 5,
	parameter int PENDING_DEPTH = 16,
	parameter int COUNT_WIDTH   = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [cod_pkg::ID_W-1:0]       cfg_data,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [cod_pkg::S_DATA_W-1:0]   s_tdata,   // sender, tag, ts_0 .. ts_4, zero pad
	input  logic [0:0]                     s_tuser,   // mode
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [cod_pkg::M_DATA_W-1:0]   m_tdata,   // out_tag, stamp_0 .. stamp_4
	output logic [1:0]                     m_tuser,   // kind
	output logic                           m_tlast
);
	import cod_pkg::*;

	localparam int IW   = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
	localparam int CNTW = $clog2(PENDING_DEPTH + 1);
	localparam int CW   = COUNT_WIDTH;
	localparam int MW   = SENDER_W + TAG_W + PROCS * CW;

	typedef logic [CW-1:0] cnt_t;

	state_t state_q, state_d;

	logic [ID_W-1:0]     own_q;
	cnt_t                dc_q [PROCS];
	cnt_t                lc_q [PROCS];

	logic                in_mode_q;
	logic [SENDER_W-1:0] in_sender_q;
	logic [TAG_W-1:0]    in_tag_q;
	cnt_t                in_stamp_q [PROCS];
	cnt_t                in_sat [PROCS];

	logic [CNTW-1:0]     cnt_q, cnt_d;
	logic [IW-1:0]       k_q, k_d;
	logic [CNTW-1:0]     w_q, w_d, w_next;
	logic                chg_q, chg_d;

	logic [MW-1:0]       mem_q [PENDING_DEPTH];
	logic [MW-1:0]       rdata_q;
	logic                mem_we, mem_re;
	logic [IW-1:0]       mem_waddr;
	logic [MW-1:0]       mem_wdata, in_word;

	logic [SENDER_W-1:0] rd_sender;
	logic [TAG_W-1:0]    rd_tag;
	cnt_t                rd_stamp [PROCS];

	logic [SENDER_W-1:0] cand_sender;
	logic [TAG_W-1:0]    cand_tag;
	cnt_t                cand_stamp [PROCS];
	logic                sender_ok, deliv;

	cnt_t                lc_bc [PROCS];

	logic                hold_valid_q;
	logic [1:0]          hold_kind_q;
	logic [TAG_W-1:0]    hold_tag_q;
	cnt_t                hold_stamp_q [PROCS];

	logic                out_valid_q, out_last_q;
	logic [1:0]          out_kind_q;
	logic [TAG_W-1:0]    out_tag_q;
	cnt_t                out_stamp_q [PROCS];

	logic                out_free, emit_ok;
	logic                emit, apply, bcast, flush, last_entry;
	logic [1:0]          emit_kind;
	cnt_t                emit_stamp [PROCS];

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign m_tvalid  = out_valid_q;
	assign m_tuser   = out_kind_q;
	assign m_tlast   = out_last_q;
	assign m_tdata[TAG_W-1:0] = out_tag_q;

	for (genvar j = 0; j < TS_FIELDS; j++) begin : g_out
		if (j < PROCS) begin : g_on
			assign m_tdata[TAG_W + TS_W*j +: TS_W] = TS_W'(out_stamp_q[j]);
		end else begin : g_off
			assign m_tdata[TAG_W + TS_W*j +: TS_W] = '0;
		end
	end

	// input saturation and store word packing
	always_comb begin
		logic [31:0] ext;
		for (int i = 0; i < PROCS; i++) begin
			ext = 32'(s_tdata[SENDER_W + TAG_W + TS_W*i +: TS_W]);
			in_sat[i] = ((ext >> CW) != 32'd0) ? '1 : CW'(ext);
		end
	end

	always_comb begin
		in_word[SENDER_W-1:0] = in_sender_q;
		in_word[SENDER_W +: TAG_W] = in_tag_q;
		for (int i = 0; i < PROCS; i++) begin
			in_word[SENDER_W + TAG_W + CW*i +: CW] = in_stamp_q[i];
		end
		rd_sender = rdata_q[SENDER_W-1:0];
		rd_tag    = rdata_q[SENDER_W +: TAG_W];
		for (int i = 0; i < PROCS; i++) begin
			rd_stamp[i] = rdata_q[SENDER_W + TAG_W + CW*i +: CW];
		end
	end

	// delivery test on the arriving word or the word read from the store
	always_comb begin
		logic ok;
		cand_sender = (state_q == ST_ARRIVE) ? in_sender_q : rd_sender;
		cand_tag    = (state_q == ST_ARRIVE) ? in_tag_q : rd_tag;
		for (int i = 0; i < PROCS; i++) begin
			cand_stamp[i] = (state_q == ST_ARRIVE) ? in_stamp_q[i] : rd_stamp[i];
		end
		sender_ok = (cand_sender < SENDER_W'(PROCS));
		ok = sender_ok;
		for (int i = 0; i < PROCS; i++) begin
			if (cand_sender == SENDER_W'(i)) begin
				if (cand_stamp[i] == '0 || dc_q[i] != cand_stamp[i] - cnt_t'(1)) begin
					ok = 1'b0;
				end
			end else if (dc_q[i] < cand_stamp[i]) begin
				ok = 1'b0;
			end
		end
		deliv = ok;
	end

	always_comb begin
		for (int i = 0; i < PROCS; i++) begin
			lc_bc[i] = lc_q[i];
			if (own_q == ID_W'(i) && lc_q[i] != '1) begin
				lc_bc[i] = lc_q[i] + cnt_t'(1);
			end
		end
	end

	assign out_free = !out_valid_q || m_tready;
	assign emit_ok  = !hold_valid_q || out_free;
	assign w_next   = w_q + (deliv ? CNTW'(0) : CNTW'(1));
	assign last_entry = ((CNTW'(k_q) + CNTW'(1)) == cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		logic go;
		state_d   = state_q;
		emit      = 1'b0;
		emit_kind = KIND_DELIVER;
		for (int i = 0; i < PROCS; i++) begin
			emit_stamp[i] = cand_stamp[i];
		end
		apply     = 1'b0;
		bcast     = 1'b0;
		flush     = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_waddr = cnt_q[IW-1:0];
		mem_wdata = in_word;
		cnt_d     = cnt_q;
		k_d       = k_q;
		w_d       = w_q;
		chg_d     = chg_q;
		go        = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_ARRIVE;
				end
			end
			ST_ARRIVE: begin
				if (in_mode_q == MODE_BCAST) begin
					if (emit_ok) begin
						bcast     = 1'b1;
						emit      = 1'b1;
						emit_kind = KIND_STAMP;
						for (int i = 0; i < PROCS; i++) begin
							emit_stamp[i] = lc_bc[i];
						end
						state_d = ST_FLUSH;
					end
				end else if (!sender_ok) begin
					state_d = ST_IDLE;
				end else if (deliv) begin
					if (emit_ok) begin
						apply = 1'b1;
						emit  = 1'b1;
						go    = 1'b1;
					end
				end else if (cnt_q < CNTW'(PENDING_DEPTH)) begin
					mem_we = 1'b1;
					cnt_d  = cnt_q + CNTW'(1);
					go     = 1'b1;
				end else if (emit_ok) begin
					emit      = 1'b1;
					emit_kind = KIND_DROP;
					go        = 1'b1;
				end
				if (go) begin
					k_d     = '0;
					w_d     = '0;
					chg_d   = 1'b0;
					state_d = (cnt_d == '0) ? ST_FLUSH : ST_READ;
				end
			end
			ST_READ: begin
				mem_re  = 1'b1;
				state_d = ST_EVAL;
			end
			ST_EVAL: begin
				if (!deliv || emit_ok) begin
					if (deliv) begin
						apply = 1'b1;
						emit  = 1'b1;
					end else begin
						mem_we    = 1'b1;
						mem_waddr = w_q[IW-1:0];
						mem_wdata = rdata_q;
					end
					if (last_entry) begin
						cnt_d = w_next;
						k_d   = '0;
						w_d   = '0;
						chg_d = 1'b0;
						state_d = ((chg_q || deliv) && w_next != '0) ? ST_READ : ST_FLUSH;
					end else begin
						k_d     = k_q + IW'(1);
						w_d     = w_next;
						chg_d   = chg_q || deliv;
						state_d = ST_READ;
					end
				end
			end
			ST_FLUSH: begin
				if (!hold_valid_q) begin
					state_d = ST_IDLE;
				end else if (out_free) begin
					flush   = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// pending store
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem_q[k_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_q        <= '0;
			cnt_q        <= '0;
			k_q          <= '0;
			w_q          <= '0;
			chg_q        <= 1'b0;
			hold_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			for (int i = 0; i < PROCS; i++) begin
				dc_q[i] <= '0;
				lc_q[i] <= '0;
			end
		end else begin
			if (cfg_valid) begin
				own_q <= cfg_data;
			end
			cnt_q <= cnt_d;
			k_q   <= k_d;
			w_q   <= w_d;
			chg_q <= chg_d;
			if (apply) begin
				for (int i = 0; i < PROCS; i++) begin
					if (cand_sender == SENDER_W'(i)) begin
						dc_q[i] <= cand_stamp[i];
					end
					if (own_q != ID_W'(i) && cand_stamp[i] > lc_q[i]) begin
						lc_q[i] <= cand_stamp[i];
					end
				end
			end
			if (bcast) begin
				for (int i = 0; i < PROCS; i++) begin
					lc_q[i] <= lc_bc[i];
				end
			end
			if ((emit && hold_valid_q) || flush) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (emit) begin
				hold_valid_q <= 1'b1;
			end else if (flush) begin
				hold_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			in_mode_q   <= s_tuser[0];
			in_sender_q <= s_tdata[SENDER_W-1:0];
			in_tag_q    <= s_tdata[SENDER_W +: TAG_W];
			for (int i = 0; i < PROCS; i++) begin
				in_stamp_q[i] <= in_sat[i];
			end
		end
		if ((emit && hold_valid_q) || flush) begin
			out_kind_q <= hold_kind_q;
			out_tag_q  <= hold_tag_q;
			out_last_q <= flush;
			for (int i = 0; i < PROCS; i++) begin
				out_stamp_q[i] <= hold_stamp_q[i];
			end
		end
		if (emit) begin
			hold_kind_q <= emit_kind;
			hold_tag_q  <= cand_tag;
			for (int i = 0; i < PROCS; i++) begin
				hold_stamp_q[i] <= emit_stamp[i];
			end
		end
	end

endmodule

[rtl/cod_checker.sv]
// cod_checker: port-level checks of the causal order delivery buffer
// depends on cod_pkg; bound to causal_order_delivery_buffer below
module cod_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tvalid,
	input logic                         s_tready,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [cod_pkg::M_DATA_W-1:0] m_tdata,
	input logic [1:0]                   m_tuser,
	input logic                         m_tlast
);
	import cod_pkg::*;

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("result word changed under stall");

	// a broadcast stamp is always the only result of its word
	a_stamp_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_STAMP |-> m_tlast)
		else $error("broadcast stamp without last");

	// one word at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while busy");

	// kind code range on the result side
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser == KIND_DELIVER || m_tuser == KIND_STAMP || m_tuser == KIND_DROP)
		else $error("bad result kind");

endmodule

bind causal_order_delivery_buffer cod_checker u_cod_checker (.*);

[test/tb_top.sv]
// tb_top: self-checking bench for causal_order_delivery_buffer
// depends on cod_pkg and the top level; predicts results of each accepted word
`timescale 1ns / 1ps
module tb_top;
	import cod_pkg::*;

	localparam int NPROC = 5;
	localparam int DEPTH = 16;
	localparam logic [15:0] CMAX = 16'hffff;

	typedef struct packed {
		logic       mode;
		logic [2:0] sender;
		logic [15:0] tag;
		logic [4:0][15:0] ts;
	} msg_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [15:0] tag;
		logic [4:0][15:0] stamp;
		logic       last;
	} res_t;

	logic clk, arst_n;
	logic cfg_valid, cfg_ready;
	logic [ID_W-1:0] cfg_data;
	logic s_tvalid, s_tready;
	logic [S_DATA_W-1:0] s_tdata;
	logic [0:0] s_tuser;
	logic m_tvalid, m_tready;
	logic [M_DATA_W-1:0] m_tdata;
	logic [1:0] m_tuser;
	logic m_tlast;

	causal_order_delivery_buffer i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	msg_t pending_words[$];
	res_t expected_results[$];
	int send_idle_pct, recv_idle_pct;
	int errors, n_words, n_results, n_deliver, n_drop, n_stamp;

	logic [2:0] own_id;
	logic [15:0] dcount[NPROC];
	logic [15:0] lclock[NPROC];
	int store_n;
	logic [2:0] store_sender[DEPTH];
	logic [15:0] store_tag[DEPTH];
	logic [4:0][15:0] store_ts[DEPTH];

	// word accepted at the last rising edge
	logic s_tready_q;

	// rough shadow of delivered counts used to shape random stamps
	logic [15:0] dcount_hint[NPROC];

	function automatic bit can_deliver(logic [2:0] s, logic [4:0][15:0] st);
		if (s >= NPROC || st[s] == 0 || dcount[s] != st[s] - 16'd1) return 0;
		for (int i = 0; i < NPROC; i++)
			if (i != s && dcount[i] < st[i]) return 0;
		return 1;
	endfunction

	task automatic deliver(logic [2:0] s, logic [15:0] tg, logic [4:0][15:0] st);
		res_t r;
		dcount[s] = st[s];
		for (int i = 0; i < NPROC; i++)
			if (i != own_id && st[i] > lclock[i]) lclock[i] = st[i];
		r = '{kind: KIND_DELIVER, tag: tg, stamp: st, last: 1'b0};
		expected_results.push_back(r);
	endtask

	task automatic predict_word(msg_t w);
		res_t r;
		int n_prior;
		bit changed;
		int k;
		n_prior = expected_results.size();
		if (w.mode == MODE_BCAST) begin
			if (own_id < NPROC && lclock[own_id] < CMAX) lclock[own_id]++;
			r.kind = KIND_STAMP;
			r.tag = w.tag;
			for (int i = 0; i < NPROC; i++) r.stamp[i] = lclock[i];
			r.last = 1'b1;
			expected_results.push_back(r);
			return;
		end
		if (w.sender >= NPROC) return;
		if (can_deliver(w.sender, w.ts)) begin
			deliver(w.sender, w.tag, w.ts);
		end else if (store_n < DEPTH) begin
			store_sender[store_n] = w.sender;
			store_tag[store_n] = w.tag;
			store_ts[store_n] = w.ts;
			store_n++;
		end else begin
			r = '{kind: KIND_DROP, tag: w.tag, stamp: w.ts, last: 1'b0};
			expected_results.push_back(r);
		end
		do begin
			changed = 0;
			k = 0;
			while (k < store_n) begin
				if (can_deliver(store_sender[k], store_ts[k])) begin
					deliver(store_sender[k], store_tag[k], store_ts[k]);
					for (int m = k; m + 1 < store_n; m++) begin
						store_sender[m] = store_sender[m + 1];
						store_tag[m] = store_tag[m + 1];
						store_ts[m] = store_ts[m + 1];
					end
					store_n--;
					changed = 1;
				end else begin
					k++;
				end
			end
		end while (changed && store_n > 0);
		if (expected_results.size() > n_prior)
			expected_results[$].last = 1'b1;
	endtask

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// driver
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
			if (!s_tvalid || s_tready_q) begin
				if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tuser <= pending_words[0].mode;
					s_tdata <= {5'd0, pending_words[0].ts[4], pending_words[0].ts[3],
						pending_words[0].ts[2], pending_words[0].ts[1], pending_words[0].ts[0],
						pending_words[0].tag, pending_words[0].sender};
					void'(pending_words.pop_front());
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tready_q <= 1'b0;
			own_id = 3'd0;
		end else begin
			s_tready_q <= s_tvalid && s_tready;
			if (s_tvalid && s_tready) begin
				msg_t w;
				w.mode = s_tuser[0];
				{w.ts[4], w.ts[3], w.ts[2], w.ts[1], w.ts[0], w.tag, w.sender} = s_tdata[98:0];
				predict_word(w);
				n_words++;
			end
			if (cfg_valid && cfg_ready) own_id = cfg_data;
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			res_t got, exp_r;
			got.kind = m_tuser;
			{got.stamp[4], got.stamp[3], got.stamp[2], got.stamp[1], got.stamp[0], got.tag} = m_tdata;
			got.last = m_tlast;
			n_results++;
			if (expected_results.size() == 0) begin
				$display("%0t unexpected result: exp none got %h", $time, got);
				errors++;
			end else begin
				exp_r = expected_results.pop_front();
				if (got.kind != exp_r.kind)
					$display("%0t kind mismatch: exp %0d got %0d", $time, exp_r.kind, got.kind);
				if (got.tag != exp_r.tag)
					$display("%0t tag mismatch: exp %h got %h", $time, exp_r.tag, got.tag);
				if (got.stamp != exp_r.stamp)
					$display("%0t stamp mismatch: exp %h got %h", $time, exp_r.stamp, got.stamp);
				if (got.last != exp_r.last)
					$display("%0t last mismatch: exp %0d got %0d", $time, exp_r.last, got.last);
				if (got != exp_r) errors++;
				case (got.kind)
					KIND_DELIVER: n_deliver++;
					KIND_DROP: n_drop++;
					default: n_stamp++;
				endcase
			end
		end
	end

	task automatic wait_drained();
		while (pending_words.size() > 0 || s_tvalid || expected_results.size() > 0)
			@(posedge clk);
		repeat (600) @(posedge clk);
	endtask

	task automatic write_own_id(logic [2:0] v);
		@(negedge clk);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic msg_t rand_word(bit wild);
		msg_t w;
		w.mode = ($urandom_range(9) == 0);
		w.sender = wild ? 3'($urandom) : 3'($urandom_range(NPROC - 1));
		w.tag = 16'($urandom);
		for (int i = 0; i < NPROC; i++)
			w.ts[i] = wild ? 16'($urandom) : 16'($urandom_range(dcount_hint[i] + 1));
		if (!wild && w.mode == MODE_RECV) w.ts[w.sender] = dcount_hint[w.sender] + 16'($urandom_range(2));
		return w;
	endfunction

	function automatic msg_t mk(logic m, logic [2:0] s, logic [15:0] tg, logic [4:0][15:0] st);
		msg_t w;
		w.mode = m;
		w.sender = s;
		w.tag = tg;
		w.ts = st;
		return w;
	endfunction

	initial begin
		msg_t w;
		errors = 0; n_words = 0; n_results = 0; n_deliver = 0; n_drop = 0; n_stamp = 0;
		store_n = 0;
		for (int i = 0; i < NPROC; i++) begin
			dcount[i] = 0; lclock[i] = 0; dcount_hint[i] = 0;
		end
		send_idle_pct = 33; recv_idle_pct = 58;
		arst_n = 0; cfg_valid = 0; cfg_data = 0;
		repeat (9) @(posedge clk);
		@(negedge clk) arst_n = 1;

		// directed: broadcast, out-of-order, zero entry, bad sender, own sender, overflow
		write_own_id(3'd4);
		pending_words.push_back(mk(MODE_BCAST, 3'd0, 16'h0000, '0));
		pending_words.push_back(mk(MODE_RECV, 3'd1, 16'h0102, {16'd0, 16'd0, 16'd0, 16'd2, 16'd0}));
		pending_words.push_back(mk(MODE_RECV, 3'd1, 16'h0101, {16'd0, 16'd0, 16'd0, 16'd1, 16'd0}));
		pending_words.push_back(mk(MODE_RECV, 3'd2, 16'hffff, '0));
		pending_words.push_back(mk(MODE_RECV, 3'd7, 16'h7777, {5{16'hffff}}));
		pending_words.push_back(mk(MODE_RECV, 3'd5, 16'h5555, {16'd0, 16'd0, 16'd0, 16'd0, 16'd1}));
		pending_words.push_back(mk(MODE_RECV, 3'd4, 16'h4444, {16'd1, 16'd0, 16'd0, 16'd2, 16'd0}));
		for (int i = 0; i < 18; i++)
			pending_words.push_back(mk(MODE_RECV, 3'd0, 16'(16'ha000 + i),
				{16'd1, 16'd0, 16'd0, 16'd0, 16'(i + 2)}));
		pending_words.push_back(mk(MODE_RECV, 3'd0, 16'ha0ff, {16'd0, 16'd0, 16'd0, 16'd0, 16'd1}));
		wait_drained();
		pending_words.push_back(mk(MODE_RECV, 3'd4, 16'h4445, {16'd1, 16'd0, 16'd0, 16'd2, 16'd0}));
		pending_words.push_back(mk(MODE_BCAST, 3'd0, 16'hbcbc, '0));
		wait_drained();

		for (int ph = 0; ph < 4; ph++) begin
			if (ph == 1) begin
				send_idle_pct = 58; recv_idle_pct = 33;
			end else if (ph >= 2) begin
				send_idle_pct = 0; recv_idle_pct = 0;
			end
			write_own_id(ph == 0 ? 3'd0 : ph == 1 ? 3'd7 : ph == 2 ? 3'd2 : 3'd5);
			for (int i = 0; i < NPROC; i++) dcount_hint[i] = dcount[i];
			for (int n = 0; n < 70; n++) begin
				w = rand_word($urandom_range(9) < 2);
				if (w.mode == MODE_RECV && w.sender < NPROC && $urandom_range(1))
					dcount_hint[w.sender] = w.ts[w.sender];
				pending_words.push_back(w);
				if (n == 40) begin
					// hold off until the block has caught up
					while (pending_words.size() > 0 || s_tvalid || expected_results.size() > 0)
						@(posedge clk);
					for (int i = 0; i < NPROC; i++) dcount_hint[i] = dcount[i];
				end
			end
			wait_drained();
		end

		$display("covered %0d words: %0d delivered, %0d stamped, %0d dropped",
			n_words, n_deliver, n_stamp, n_drop);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("PASS causal_order_delivery_buffer");
		end else begin
			$display("FAIL causal_order_delivery_buffer");
		end
		$finish;
	end

	initial begin
		#50ms;
		$display("FAIL causal_order_delivery_buffer");
		$finish;
	end

endmodule
